FILE: hw/rtl/psc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psc_pkg
// Shared types, widths and constants for the clamped PID speed controller.
// ----------------------------------------------------------------------------
package psc_pkg;

	localparam int FRAC_BITS = 8;

	// field widths
	localparam int IN_W      = 16;
	localparam int GAIN_W    = 16;
	localparam int OFS_W     = 18;
	localparam int OUT_W     = 17;
	localparam int CFG_IDX_W = 8;
	localparam int CFG_W     = 18;

	// internal widths
	localparam int ERR_W    = 24;
	localparam int SUM_W    = 15;
	localparam int DIFF_W   = ERR_W + 1;
	localparam int DERIV_W  = 32;
	localparam int TERM_W   = 18;
	localparam int P_PROD_W = GAIN_W + 1 + ERR_W;
	localparam int I_PROD_W = GAIN_W + 1 + SUM_W;
	localparam int D_PROD_W = GAIN_W + 1 + DERIV_W;
	localparam int TOTAL_W  = D_PROD_W + 1;

	// limits in fixed point
	localparam int SUM_LIMIT  = 50 << FRAC_BITS;
	localparam int TERM_LIMIT = 500 << FRAC_BITS;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_KP_GAIN      = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_KI_GAIN      = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_KD_GAIN      = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_DRIVE_OFFSET = CFG_IDX_W'(3);

	// register reset values
	localparam logic [GAIN_W-1:0]       KP_RESET     = GAIN_W'(48640);
	localparam logic [GAIN_W-1:0]       KI_RESET     = GAIN_W'(17920);
	localparam logic [GAIN_W-1:0]       KD_RESET     = GAIN_W'(335);
	localparam logic signed [OFS_W-1:0] OFFSET_RESET = '0;

	typedef logic signed [ERR_W-1:0]  err_t;
	typedef logic signed [SUM_W-1:0]  sum_t;
	typedef logic signed [DIFF_W-1:0] diff_t;

	typedef struct packed {
		logic signed [IN_W-1:0] set_speed;
		logic signed [IN_W-1:0] measured_speed;
		logic                   direction;
	} psc_in_t;

	typedef struct packed {
		logic [OUT_W-1:0] drive_value;
		logic             drive_direction;
	} psc_out_t;

endpackage

FILE: hw/rtl/psc_error_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psc_error_stage
// Speed error, clamped integral and error difference, with the controller
// state registers.
// ----------------------------------------------------------------------------
module psc_error_stage import psc_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load,
	input  logic signed [IN_W-1:0] set_speed,
	input  logic signed [IN_W-1:0] measured_speed,
	output err_t                   err_s2,
	output sum_t                   sum_s2,
	output diff_t                  diff_s2
);

	localparam logic signed [ERR_W:0] SumHi = (ERR_W + 1)'(SUM_LIMIT);
	localparam logic signed [ERR_W:0] SumLo = -SumHi;

	sum_t                  error_sum_q;
	err_t                  previous_error_q;
	err_t                  sp_ext;
	err_t                  ms_ext;
	err_t                  ms_scaled;
	err_t                  err_now;
	logic signed [ERR_W:0] sum_wide;
	sum_t                  sum_next;
	diff_t                 diff_now;

	always_comb begin
		sp_ext    = $signed({{(ERR_W - IN_W){set_speed[IN_W-1]}}, set_speed});
		ms_ext    = $signed({{(ERR_W - IN_W){measured_speed[IN_W-1]}}, measured_speed});
		// times 100
		ms_scaled = (ms_ext <<< 6) + (ms_ext <<< 5) + (ms_ext <<< 2);
		err_now   = sp_ext - ms_scaled;
		sum_wide  = $signed({{(ERR_W + 1 - SUM_W){error_sum_q[SUM_W-1]}}, error_sum_q})
			+ $signed({err_now[ERR_W-1], err_now});
		if (sum_wide > SumHi) begin
			sum_next = SumHi[SUM_W-1:0];
		end else if (sum_wide < SumLo) begin
			sum_next = SumLo[SUM_W-1:0];
		end else begin
			sum_next = sum_wide[SUM_W-1:0];
		end
		diff_now  = $signed({err_now[ERR_W-1], err_now})
			- $signed({previous_error_q[ERR_W-1], previous_error_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			error_sum_q      <= '0;
			previous_error_q <= '0;
		end else if (load) begin
			error_sum_q      <= sum_next;
			previous_error_q <= err_now;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			err_s2  <= err_now;
			sum_s2  <= sum_next;
			diff_s2 <= diff_now;
		end
	end

endmodule

FILE: hw/rtl/pid_speed_controller_clamped.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_speed_controller_clamped
// PID speed controller with integral clamp and clamped drive output.
// ----------------------------------------------------------------------------
// datapath: a result beat passes through in_s1, the error stage, the s3 and s4 registers and out_q
// throughput: one beat per cycle while out_ready does not stall the output, through the five-stage registered datapath
// stall: each stage holds its beat while the next stage is full and stalled
// reset: clears valid bits and the integral and previous error state,
// gains and offset return to their defaults
module pid_speed_controller_clamped import psc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  psc_in_t              in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output psc_out_t             out_data,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam logic signed [P_PROD_W-1:0] PHi = P_PROD_W'(TERM_LIMIT);
	localparam logic signed [P_PROD_W-1:0] PLo = -PHi;
	localparam logic signed [I_PROD_W-1:0] IHi = I_PROD_W'(TERM_LIMIT);
	localparam logic signed [I_PROD_W-1:0] ILo = -IHi;
	localparam logic signed [TOTAL_W-1:0]  THi = TOTAL_W'(TERM_LIMIT);

	// configuration registers
	logic [GAIN_W-1:0]       kp_q;
	logic [GAIN_W-1:0]       ki_q;
	logic [GAIN_W-1:0]       kd_q;
	logic signed [OFS_W-1:0] offset_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q     <= KP_RESET;
			ki_q     <= KI_RESET;
			kd_q     <= KD_RESET;
			offset_q <= OFFSET_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_KP_GAIN: begin
					kp_q <= cfg_data[GAIN_W-1:0];
				end
				REG_KI_GAIN: begin
					ki_q <= cfg_data[GAIN_W-1:0];
				end
				REG_KD_GAIN: begin
					kd_q <= cfg_data[GAIN_W-1:0];
				end
				REG_DRIVE_OFFSET: begin
					offset_q <= $signed(cfg_data[OFS_W-1:0]);
				end
				default: begin
				end
			endcase
		end
	end

	// pipeline control
	logic v_s1, v_s2, v_s3, v_s4, out_valid_q;
	logic en_s1, en_s2, en_s3, en_s4, en_o;

	assign en_o  = !out_valid_q || out_ready;
	assign en_s4 = !v_s4 || en_o;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;
	assign in_ready  = en_s1;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_o) out_valid_q <= v_s4;
		end
	end

	// stage 1: input register
	psc_in_t in_s1;

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			in_s1 <= in_data;
		end
	end

	// stage 2: error, integral, difference
	err_t  err_s2;
	sum_t  sum_s2;
	diff_t diff_s2;
	logic  dir_s2;

	psc_error_stage u_error_stage (
		.clk            (clk),
		.arst_n         (arst_n),
		.load           (en_s2 && v_s1),
		.set_speed      (in_s1.set_speed),
		.measured_speed (in_s1.measured_speed),
		.err_s2         (err_s2),
		.sum_s2         (sum_s2),
		.diff_s2        (diff_s2)
	);

	always_ff @(posedge clk) begin
		if (en_s2 && v_s1) begin
			dir_s2 <= in_s1.direction;
		end
	end

	// stage 3: P and I products, derivative
	logic signed [P_PROD_W-1:0] p_prod;
	logic signed [I_PROD_W-1:0] i_prod;
	logic signed [DERIV_W-1:0]  diff_ext;
	logic signed [DERIV_W-1:0]  deriv;
	logic signed [P_PROD_W-1:0] p_prod_s3;
	logic signed [I_PROD_W-1:0] i_prod_s3;
	logic signed [DERIV_W-1:0]  deriv_s3;
	logic                       dir_s3;

	always_comb begin
		p_prod   = P_PROD_W'($signed({1'b0, kp_q})) * P_PROD_W'(err_s2);
		i_prod   = I_PROD_W'($signed({1'b0, ki_q})) * I_PROD_W'(sum_s2);
		diff_ext = $signed({{(DERIV_W - DIFF_W){diff_s2[DIFF_W-1]}}, diff_s2});
		// times 100
		deriv    = (diff_ext <<< 6) + (diff_ext <<< 5) + (diff_ext <<< 2);
	end

	always_ff @(posedge clk) begin
		if (en_s3 && v_s2) begin
			p_prod_s3 <= p_prod;
			i_prod_s3 <= i_prod;
			deriv_s3  <= deriv;
			dir_s3    <= dir_s2;
		end
	end

	// stage 4: clamp P and I, D product
	logic signed [P_PROD_W-1:0] p_shift;
	logic signed [I_PROD_W-1:0] i_shift;
	logic signed [TERM_W-1:0]   p_term;
	logic signed [TERM_W-1:0]   i_term;
	logic signed [D_PROD_W-1:0] d_prod;
	logic signed [TERM_W-1:0]   p_s4;
	logic signed [TERM_W-1:0]   i_s4;
	logic signed [D_PROD_W-1:0] d_prod_s4;
	logic                       dir_s4;

	always_comb begin
		p_shift = p_prod_s3 >>> FRAC_BITS;
		i_shift = i_prod_s3 >>> FRAC_BITS;
		if (p_shift > PHi) begin
			p_term = PHi[TERM_W-1:0];
		end else if (p_shift < PLo) begin
			p_term = PLo[TERM_W-1:0];
		end else begin
			p_term = p_shift[TERM_W-1:0];
		end
		if (i_shift > IHi) begin
			i_term = IHi[TERM_W-1:0];
		end else if (i_shift < ILo) begin
			i_term = ILo[TERM_W-1:0];
		end else begin
			i_term = i_shift[TERM_W-1:0];
		end
		d_prod = D_PROD_W'($signed({1'b0, kd_q})) * D_PROD_W'(deriv_s3);
	end

	always_ff @(posedge clk) begin
		if (en_s4 && v_s3) begin
			p_s4      <= p_term;
			i_s4      <= i_term;
			d_prod_s4 <= d_prod;
			dir_s4    <= dir_s3;
		end
	end

	// stage 5: sum and output clamp
	logic signed [D_PROD_W-1:0] d_term;
	logic signed [TOTAL_W-1:0]  total;
	logic [OUT_W-1:0]           drive;
	psc_out_t                   out_q;

	always_comb begin
		d_term = d_prod_s4 >>> FRAC_BITS;
		total  = $signed({{(TOTAL_W - TERM_W){p_s4[TERM_W-1]}}, p_s4})
			+ $signed({{(TOTAL_W - TERM_W){i_s4[TERM_W-1]}}, i_s4})
			+ $signed({d_term[D_PROD_W-1], d_term})
			+ $signed({{(TOTAL_W - OFS_W){offset_q[OFS_W-1]}}, offset_q});
		if (total > THi) begin
			drive = THi[OUT_W-1:0];
		end else if (total < TOTAL_W'(0)) begin
			drive = '0;
		end else begin
			drive = total[OUT_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en_o && v_s4) begin
			out_q.drive_value     <= drive;
			out_q.drive_direction <= dir_s4;
		end
	end

	assign out_data = out_q;

endmodule

FILE: hw/rtl/psc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psc_checker
// Port-level assertions for the clamped PID speed controller.
// ----------------------------------------------------------------------------
module psc_checker import psc_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     in_ready,
	input logic     out_valid,
	input logic     out_ready,
	input psc_out_t out_data
);

	// stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result beat changed while stalled");

	// drive stays within 0..128000, i.e. 0..500 with 8 fraction bits
	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.drive_value <= OUT_W'(TERM_LIMIT))
		else $error("drive value above limit");

	// empty output means the whole pipe can move
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

	// no result beat right after reset
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !out_valid)
		else $error("result beat right after reset");

endmodule

bind pid_speed_controller_clamped psc_checker u_psc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

FILE: dv/pid_speed_controller_clamped_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_speed_controller_clamped_test
// Self-checking bench for the clamped PID speed controller. A transaction-level
// predictor keeps its own integral, previous error, gains and offset, computes
// the drive beat for every accepted sample and compares it field by field with
// the beats that come out. Directed samples cover the field extremes and the
// register corner cases. Random phases follow with random gains, random idling
// on both channels, a long output hold-off and a full drain in mid-stream.
// ----------------------------------------------------------------------------
module pid_speed_controller_clamped_test import psc_pkg::*;;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 8;
	localparam int HOLD_OFF_LEN   = 300;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_ready;
	psc_in_t              in_data   = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	psc_out_t             out_data;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data  = '0;

	pid_speed_controller_clamped dut (.*);

	// predictor state and register copies
	logic [GAIN_W-1:0] kp       = KP_RESET;
	logic [GAIN_W-1:0] ki       = KI_RESET;
	logic [GAIN_W-1:0] kd       = KD_RESET;
	longint            offset   = 0;
	longint            integ    = 0;
	longint            last_err = 0;

	psc_out_t pending_drive[$];
	psc_out_t want;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_off_req  = 0;
	int hold_left     = 0;
	int fail_count    = 0;
	int beats_in      = 0;
	int beats_out     = 0;
	int reg_writes    = 0;
	int quiet_cycles  = 0;
	int drive_zero    = 0;
	int drive_full    = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic longint clip(input longint x, input longint lo, input longint hi);
		if (x > hi)
			return hi;
		if (x < lo)
			return lo;
		return x;
	endfunction

	// unsigned q8.8 gain times signed value, floor back to the value's scale
	function automatic longint gain_product(input logic [GAIN_W-1:0] g, input longint v);
		return (longint'(g) * v) >>> FRAC_BITS;
	endfunction

	function automatic psc_out_t predict_drive(input psc_in_t s);
		longint err, deriv, p, i, d;
		psc_out_t r;
		err = longint'($signed(s.set_speed)) - 100 * longint'($signed(s.measured_speed));
		integ = clip(integ + err, -SUM_LIMIT, SUM_LIMIT);
		deriv = (err - last_err) * 100;
		p = clip(gain_product(kp, err), -TERM_LIMIT, TERM_LIMIT);
		i = clip(gain_product(ki, integ), -TERM_LIMIT, TERM_LIMIT);
		d = gain_product(kd, deriv);
		last_err = err;
		r.drive_value = OUT_W'(clip(p + i + d + offset, 0, TERM_LIMIT));
		r.drive_direction = s.direction;
		return r;
	endfunction

	function automatic psc_in_t sample(input int sp, input int ms, input bit dir);
		psc_in_t s;
		s.set_speed = IN_W'(sp);
		s.measured_speed = IN_W'(ms);
		s.direction = dir;
		return s;
	endfunction

	// mostly near-balanced setpoint and speed so the loop stays off the clamps
	function automatic psc_in_t random_sample();
		int ms, span;
		if ($urandom_range(3) == 0)
			return sample(int'($urandom), int'($urandom), 1'($urandom_range(1)));
		ms = int'($urandom_range(128)) - 64;
		span = 64 << (2 * $urandom_range(2));
		return sample(100 * ms + int'($urandom_range(2 * span)) - span, ms,
			1'($urandom_range(1)));
	endfunction

	function automatic logic [GAIN_W-1:0] random_gain();
		case ($urandom_range(4))
		0: return '0;
		1: return '1;
		default: return GAIN_W'($urandom_range(65535) >> $urandom_range(10));
		endcase
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val,
			input bit last);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		if (last)
			cfg_we <= 1'b0;
		case (idx)
		REG_KP_GAIN: kp = val[GAIN_W-1:0];
		REG_KI_GAIN: ki = val[GAIN_W-1:0];
		REG_KD_GAIN: kd = val[GAIN_W-1:0];
		REG_DRIVE_OFFSET: offset = longint'($signed(val[OFS_W-1:0]));
		default: ;
		endcase
		reg_writes++;
	endtask

	task automatic set_gains(input logic [GAIN_W-1:0] p, input logic [GAIN_W-1:0] i,
			input logic [GAIN_W-1:0] d, input logic [CFG_W-1:0] ofs);
		write_reg(REG_KP_GAIN, CFG_W'(p), 1'b0);
		write_reg(REG_KI_GAIN, CFG_W'(i), 1'b0);
		write_reg(REG_KD_GAIN, CFG_W'(d), 1'b0);
		write_reg(REG_DRIVE_OFFSET, ofs, 1'b1);
	endtask

	// valid stays high after the beat; the next call or wait_idle decides
	task automatic send_sample(input psc_in_t s);
		int gap;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct)
			gap++;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= s;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pending_drive.push_back(predict_drive(s));
		beats_in++;
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_drive.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic test_reset_defaults();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		send_sample(sample(0, 0, 1'b0));
		send_sample(sample(32767, -32768, 1'b1));
		send_sample(sample(-32768, 32767, 1'b0));
		send_sample(sample(32767, 32767, 1'b1));
		send_sample(sample(-32768, -32768, 1'b0));
		send_sample(sample(256, 0, 1'b1));
		send_sample(sample(256, 0, 1'b0));
		send_sample(sample(-256, 0, 1'b1));
		send_sample(sample(0, 1, 1'b0));
		wait_idle();
	endtask

	task automatic test_register_writes();
		// out-of-range indexes are ignored, bits above the gain width are dropped
		write_reg(CFG_IDX_W'(4), '1, 1'b0);
		write_reg('1, CFG_W'(12345), 1'b0);
		write_reg(REG_KP_GAIN, CFG_W'('h30100), 1'b0);
		write_reg(REG_KI_GAIN, CFG_W'(0), 1'b0);
		write_reg(REG_KD_GAIN, '1, 1'b0);
		write_reg(REG_DRIVE_OFFSET, CFG_W'(128000), 1'b1);
		// large derivative with max kd
		send_sample(sample(32767, -32768, 1'b0));
		send_sample(sample(-32768, 32767, 1'b1));
		send_sample(sample(0, 0, 1'b0));
		wait_idle();
		set_gains('0, '0, '0, CFG_W'('h20000));
		send_sample(sample(1000, 0, 1'b1));
		wait_idle();
		write_reg(REG_DRIVE_OFFSET, CFG_W'('h1FFFF), 1'b1);
		send_sample(sample(-1000, 0, 1'b0));
		wait_idle();
		set_gains('1, '1, '0, CFG_W'(-128000));
		send_sample(sample(12, 0, 1'b1));
		send_sample(sample(-12, 0, 1'b0));
		send_sample(sample(1200, 12, 1'b1));
		wait_idle();
	endtask

	task automatic run_random_phase(input int send_pct, input int recv_pct, input int count,
			input bit pressure);
		logic [CFG_W-1:0] ofs;
		wait_idle();
		case ($urandom_range(3))
		0: ofs = CFG_W'($urandom);
		1: ofs = '0;
		default: ofs = CFG_W'(int'($urandom_range(65536)) - 32768);
		endcase
		set_gains(random_gain(), random_gain(), random_gain(), ofs);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		for (int n = 0; n < count; n++) begin
			if (pressure && n == count / 3)
				hold_off_req = HOLD_OFF_LEN;
			if (pressure && n == 2 * count / 3)
				wait_idle();
			send_sample(random_sample());
		end
		wait_idle();
	endtask

	task automatic test_backpressure();
		for (int k = 0; k < 3; k++)
			run_random_phase(25, 73, 50, k == 1);
	endtask

	task automatic test_sender_gaps();
		for (int k = 0; k < 3; k++)
			run_random_phase(73, 25, 50, 1'b0);
	endtask

	task automatic test_full_rate();
		for (int k = 0; k < 3; k++)
			run_random_phase(0, 0, 50, 1'b0);
	endtask

	// result check and receiver ready
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			beats_out++;
			if (pending_drive.size() == 0) begin
				$error("drive beat with no sample pending: drive_value %0d", out_data.drive_value);
				fail_count++;
			end else begin
				want = pending_drive.pop_front();
				if (out_data.drive_value !== want.drive_value) begin
					$error("drive_value: expected %0d, got %0d", want.drive_value,
						out_data.drive_value);
					fail_count++;
				end
				if (out_data.drive_direction !== want.drive_direction) begin
					$error("drive_direction: expected %0b, got %0b", want.drive_direction,
						out_data.drive_direction);
					fail_count++;
				end
				if (want.drive_value == 0)
					drive_zero++;
				if (want.drive_value == TERM_LIMIT)
					drive_full++;
			end
		end
		if (hold_off_req != 0) begin
			hold_left = hold_off_req;
			hold_off_req = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// no beat moved on either channel for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_register_writes();
		test_backpressure();
		test_sender_gaps();
		test_full_rate();
		wait_idle();
		$display("run covered %0d samples, %0d drive beats, %0d register writes",
			beats_in, beats_out, reg_writes);
		$display("drive at zero %0d times, at full scale %0d times, %0d mismatches",
			drive_zero, drive_full, fail_count);
		if (fail_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
